// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL in this folder.
// Depends on nothing; the user module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/core/tpd_pkg.sv =====
// Types and width constants for the triangle plane depth pipeline.
// Depends on nothing.
`timescale 1ns / 1ps

package tpd_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int NORM_W = PROD_W + 1;
	localparam int SPLIT = DIFF_W;
	localparam int HI_W = NORM_W - SPLIT;
	localparam int HIP_W = HI_W + DIFF_W;
	localparam int LOP_W = SPLIT + 1 + DIFF_W;
	localparam int PART_W = NORM_W + DIFF_W;
	localparam int NUM_W = PART_W + 1;
	localparam int DIVD_W = NUM_W + 1;
	localparam int QUO_W = COORD_WIDTH + 3;
	localparam int EXT_W = QUO_W + 2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] vertex0_x;
		logic signed [COORD_WIDTH-1:0] vertex0_y;
		logic signed [COORD_WIDTH-1:0] vertex0_z;
		logic signed [COORD_WIDTH-1:0] vertex1_x;
		logic signed [COORD_WIDTH-1:0] vertex1_y;
		logic signed [COORD_WIDTH-1:0] vertex1_z;
		logic signed [COORD_WIDTH-1:0] vertex2_x;
		logic signed [COORD_WIDTH-1:0] vertex2_y;
		logic signed [COORD_WIDTH-1:0] vertex2_z;
		logic signed [COORD_WIDTH-1:0] query_x;
		logic signed [COORD_WIDTH-1:0] query_y;
	} tpd_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] depth;
		logic                          degenerate;
		logic                          saturated;
	} tpd_out_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] z0;
		logic                          deg;
		logic                          neg;
		logic                          ovf;
	} tpd_side_t;

endpackage

// ===== rtl/core/triangle_plane_depth.sv =====
// Triangle plane depth: one beat in and one result beat out per clock. Most of
// the pipeline is the restoring divider, which resolves one quotient bit per
// stage. busy is always low and done pulses for the single cycle a result is
// on the result port; the receiver must take it then.
// Depends on tpd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module triangle_plane_depth (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  tpd_pkg::tpd_in_t  item,
	output logic            done,
	output tpd_pkg::tpd_out_t result
);
	import tpd_pkg::*;

	localparam int CW = COORD_WIDTH;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	tpd_side_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7;

	logic signed [DIFF_W-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [PROD_W-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [NORM_W-1:0] nx_s3, ny_s3, nz_s3, nz_s4, nz_s5, nz_s6;
	logic signed [HIP_W-1:0]  xh_s4, yh_s4;
	logic signed [LOP_W-1:0]  xl_s4, yl_s4;
	logic signed [PART_W-1:0] px_s5, py_s5;
	logic signed [NUM_W-1:0]  num_s6;
	logic [DIVD_W-1:0]        a_s7;
	logic [NORM_W-1:0]        d_s7;
	logic [NUM_W-1:0]         num_mag;
	logic [NORM_W-1:0]        nz_mag;

	logic                     vd    [0:QUO_W];
	tpd_side_t                sdd   [0:QUO_W];
	logic [DIVD_W-1:0]        rem_sd [0:QUO_W];
	logic [NORM_W-1:0]        den_sd [0:QUO_W];
	logic [QUO_W-1:0]         quo_sd [0:QUO_W];

	logic [QUO_W:0]           q_inc;
	logic [QUO_W-1:0]         q_rnd;
	logic signed [EXT_W-1:0]  q_sgn;
	logic signed [EXT_W-1:0]  dep;
	logic [EXT_W-CW:0]        dep_hi;
	logic                     in_range;
	tpd_side_t                sdf;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_comb begin
		num_mag = num_s6[NUM_W-1] ? NUM_W'(-num_s6) : NUM_W'(num_s6);
		nz_mag  = nz_s6[NORM_W-1] ? NORM_W'(-nz_s6) : NORM_W'(nz_s6);
	end

	always_ff @(posedge clk) begin
		ux_s1 <= DIFF_W'(item.vertex1_x) - DIFF_W'(item.vertex0_x);
		uy_s1 <= DIFF_W'(item.vertex1_y) - DIFF_W'(item.vertex0_y);
		uz_s1 <= DIFF_W'(item.vertex1_z) - DIFF_W'(item.vertex0_z);
		vx_s1 <= DIFF_W'(item.vertex2_x) - DIFF_W'(item.vertex0_x);
		vy_s1 <= DIFF_W'(item.vertex2_y) - DIFF_W'(item.vertex0_y);
		vz_s1 <= DIFF_W'(item.vertex2_z) - DIFF_W'(item.vertex0_z);
		dx_s1 <= DIFF_W'(item.query_x) - DIFF_W'(item.vertex0_x);
		dy_s1 <= DIFF_W'(item.query_y) - DIFF_W'(item.vertex0_y);
		sd_s1.z0  <= item.vertex0_z;
		sd_s1.deg <= 1'b0;
		sd_s1.neg <= 1'b0;
		sd_s1.ovf <= 1'b0;

		m0_s2 <= PROD_W'(uy_s1) * PROD_W'(vz_s1);
		m1_s2 <= PROD_W'(uz_s1) * PROD_W'(vy_s1);
		m2_s2 <= PROD_W'(uz_s1) * PROD_W'(vx_s1);
		m3_s2 <= PROD_W'(ux_s1) * PROD_W'(vz_s1);
		m4_s2 <= PROD_W'(ux_s1) * PROD_W'(vy_s1);
		m5_s2 <= PROD_W'(uy_s1) * PROD_W'(vx_s1);
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		sd_s2 <= sd_s1;

		nx_s3 <= NORM_W'(m0_s2) - NORM_W'(m1_s2);
		ny_s3 <= NORM_W'(m2_s2) - NORM_W'(m3_s2);
		nz_s3 <= NORM_W'(m4_s2) - NORM_W'(m5_s2);
		dx_s3 <= dx_s2;
		dy_s3 <= dy_s2;
		sd_s3 <= '{z0: sd_s2.z0, deg: (m4_s2 == m5_s2), neg: sd_s2.neg, ovf: sd_s2.ovf};

		xh_s4 <= HIP_W'($signed(nx_s3[NORM_W-1:SPLIT])) * HIP_W'(dx_s3);
		yh_s4 <= HIP_W'($signed(ny_s3[NORM_W-1:SPLIT])) * HIP_W'(dy_s3);
		xl_s4 <= LOP_W'($signed({1'b0, nx_s3[SPLIT-1:0]})) * LOP_W'(dx_s3);
		yl_s4 <= LOP_W'($signed({1'b0, ny_s3[SPLIT-1:0]})) * LOP_W'(dy_s3);
		nz_s4 <= nz_s3;
		sd_s4 <= sd_s3;

		px_s5 <= (PART_W'(xh_s4) <<< SPLIT) + PART_W'(xl_s4);
		py_s5 <= (PART_W'(yh_s4) <<< SPLIT) + PART_W'(yl_s4);
		nz_s5 <= nz_s4;
		sd_s5 <= sd_s4;

		num_s6 <= NUM_W'(px_s5) + NUM_W'(py_s5);
		nz_s6 <= nz_s5;
		sd_s6 <= sd_s5;

		a_s7 <= {num_mag, 1'b0};
		d_s7 <= nz_mag;
		sd_s7 <= '{z0: sd_s6.z0, deg: sd_s6.deg,
			neg: (num_s6[NUM_W-1] ^ nz_s6[NORM_W-1]), ovf: sd_s6.ovf};
	end

	// The divider works on twice the numerator so that the last quotient bit
	// is the half bit used for rounding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd[0] <= 1'b0;
		end else begin
			vd[0] <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		rem_sd[0] <= a_s7;
		den_sd[0] <= d_s7;
		quo_sd[0] <= '0;
		sdd[0]    <= '{z0: sd_s7.z0, deg: sd_s7.deg, neg: sd_s7.neg,
			ovf: (a_s7 >= (DIVD_W'(d_s7) << QUO_W))};
	end

	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		localparam int K = QUO_W - 1 - j;
		logic [DIVD_W-1:0] trial;
		logic              take;

		assign trial = DIVD_W'(den_sd[j]) << K;
		assign take  = (rem_sd[j] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd[j+1] <= 1'b0;
			end else begin
				vd[j+1] <= vd[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_sd[j+1] <= take ? rem_sd[j] - trial : rem_sd[j];
			quo_sd[j+1] <= quo_sd[j] | (QUO_W'(take) << K);
			den_sd[j+1] <= den_sd[j];
			sdd[j+1]    <= sdd[j];
		end
	end

	always_comb begin
		sdf      = sdd[QUO_W];
		q_inc    = (QUO_W+1)'(quo_sd[QUO_W]) + (QUO_W+1)'(1);
		q_rnd    = q_inc[QUO_W:1];
		q_sgn    = sdf.neg ? -EXT_W'(q_rnd) : EXT_W'(q_rnd);
		dep      = EXT_W'(sdf.z0) - q_sgn;
		dep_hi   = dep[EXT_W-1:CW-1];
		in_range = (&dep_hi) || !(|dep_hi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vd[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (sdf.deg) begin
			result.depth      <= '0;
			result.degenerate <= 1'b1;
			result.saturated  <= 1'b0;
		end else if (sdf.ovf) begin
			result.depth      <= sdf.neg ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			result.degenerate <= 1'b0;
			result.saturated  <= 1'b1;
		end else if (!in_range) begin
			result.depth      <= dep[EXT_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			result.degenerate <= 1'b0;
			result.saturated  <= 1'b1;
		end else begin
			result.depth      <= dep[CW-1:0];
			result.degenerate <= 1'b0;
			result.saturated  <= 1'b0;
		end
	end

	`ASSERT_IMPL(a_deg_zero, done && result.degenerate,
		result.depth == '0 && !result.saturated, "degenerate result is not clean zero")
	`ASSERT_IMPL(a_sat_bound, done && result.saturated,
		result.depth == {1'b1, {(CW-1){1'b0}}} || result.depth == {1'b0, {(CW-1){1'b1}}},
		"saturated depth is not a range bound")
	`ASSERT_NEXT(a_div_flow, vd[QUO_W], done, "divider output beat was lost")

endmodule

// ===== verif/tb_triangle_plane_depth.sv =====
// Testbench for triangle_plane_depth: drives triangles and query points, predicts
// the plane depth with wide exact integer arithmetic and checks every result beat.
// Depends on tpd_pkg and the triangle_plane_depth RTL.
`timescale 1ns / 1ps

module tb_triangle_plane_depth;
	import tpd_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	tpd_in_t  item;
	logic     done;
	tpd_out_t result;

	tpd_out_t depth_q[$];
	int       errors = 0;
	int       n_sent = 0;
	int       n_checked = 0;
	int       n_degen = 0;
	int       n_sat = 0;
	bit       no_gaps = 0;

	triangle_plane_depth uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic tpd_out_t plane_depth(tpd_in_t t);
		logic signed [127:0] ux, uy, uz, vx, vy, vz, nx, ny, nz, num;
		logic signed [127:0] an, dn, quo, rm, dep;
		tpd_out_t r;
		ux = $signed(t.vertex1_x) - $signed(t.vertex0_x);
		uy = $signed(t.vertex1_y) - $signed(t.vertex0_y);
		uz = $signed(t.vertex1_z) - $signed(t.vertex0_z);
		vx = $signed(t.vertex2_x) - $signed(t.vertex0_x);
		vy = $signed(t.vertex2_y) - $signed(t.vertex0_y);
		vz = $signed(t.vertex2_z) - $signed(t.vertex0_z);
		nx = uy * vz - uz * vy;
		ny = uz * vx - ux * vz;
		nz = ux * vy - uy * vx;
		r = '0;
		if (nz == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		num = nx * ($signed(t.query_x) - $signed(t.vertex0_x))
		    + ny * ($signed(t.query_y) - $signed(t.vertex0_y));
		an = (num < 0) ? -num : num;
		dn = (nz < 0) ? -nz : nz;
		quo = an / dn;
		rm = an % dn;
		if (2 * rm >= dn)
			quo = quo + 1;
		if ((num < 0) != (nz < 0))
			quo = -quo;
		dep = $signed(t.vertex0_z) - quo;
		if (dep > 128'sd2147483647) begin
			dep = 128'sd2147483647;
			r.saturated = 1'b1;
		end else if (dep < -128'sd2147483648) begin
			dep = -128'sd2147483648;
			r.saturated = 1'b1;
		end
		r.depth = dep[31:0];
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			depth_q.push_back(plane_depth(item));
	end

	always @(posedge clk) begin
		tpd_out_t exp_r;
		if (arst_n && done) begin
			if (depth_q.size() == 0) begin
				$error("result beat with no expected result: depth %0d", result.depth);
				errors++;
			end else begin
				exp_r = depth_q.pop_front();
				n_checked++;
				if (exp_r.degenerate) n_degen++;
				if (exp_r.saturated) n_sat++;
				if (result.depth !== exp_r.depth) begin
					$error("depth expected %0d actual %0d", exp_r.depth, result.depth);
					errors++;
				end
				if (result.degenerate !== exp_r.degenerate) begin
					$error("degenerate expected %0b actual %0b",
						exp_r.degenerate, result.degenerate);
					errors++;
				end
				if (result.saturated !== exp_r.saturated) begin
					$error("saturated expected %0b actual %0b",
						exp_r.saturated, result.saturated);
					errors++;
				end
			end
		end
	end

	task automatic send_beat(tpd_in_t v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= v;
		do @(posedge clk); while (busy !== 1'b0);
		n_sent++;
	endtask

	function automatic tpd_in_t tri_of(int x0, int y0, int z0, int x1, int y1, int z1,
		int x2, int y2, int z2, int qx, int qy);
		tpd_in_t t;
		t = '{x0, y0, z0, x1, y1, z1, x2, y2, z2, qx, qy};
		return t;
	endfunction

	task automatic test_extremes();
		int mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		send_beat(tri_of(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
		send_beat(tri_of(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
		send_beat(tri_of(mn, mn, mx, mx, mn, mn, mn, mx, mn, mx, mx));
		send_beat(tri_of(mn, mn, mn, mx, mn, mx, mn, mx, mx, mx, mx));
		send_beat(tri_of(mx, mx, mn, mn, mx, mx, mx, mn, mx, mn, mn));
		send_beat(tri_of(0, 0, mx, 1, 0, mx, 0, 1, mx, 0, 0));
		send_beat(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_beat(tri_of(-1, -1, -1, 0, -1, -1, -1, 0, -1, mx, mn));
	endtask

	task automatic test_degenerate();
		send_beat(tri_of(5, 5, 3, 5, 9, 7, 5, -4, 1, 100, 100));
		send_beat(tri_of(0, 0, 0, 65536, 65536, 10, 131072, 131072, -7, 3, 4));
		send_beat(tri_of(1, 2, 3, 1, 2, 9, 1, 2, -9, 8, 8));
	endtask

	task automatic test_rounding();
		// Half-way quotients of both signs must round away from zero.
		send_beat(tri_of(0, 0, 0, 2, 0, 1, 0, 2, 0, 1, 0));
		send_beat(tri_of(0, 0, 0, 2, 0, -1, 0, 2, 0, 1, 0));
		send_beat(tri_of(0, 0, 0, 2, 0, 1, 0, 2, 0, -1, 0));
		send_beat(tri_of(0, 0, 0, 3, 0, 1, 0, 3, 0, 1, 0));
		send_beat(tri_of(0, 0, 0, 3, 0, 2, 0, 3, 0, 1, 0));
		send_beat(tri_of(7, -3, 65536, 8, -3, 65536, 7, -1, 65537, 9, 2));
	endtask

	task automatic test_saturation();
		send_beat(tri_of(0, 0, 32'h7ffffff0, 1, 0, 32'h7ffffff0 + 0, 0, 1, 32'h7fffff00,
			0, -100));
		send_beat(tri_of(0, 0, 32'h80000010, 1, 0, 32'h80000010, 0, 1, 32'h80000100,
			0, -100));
		send_beat(tri_of(0, 0, 0, 1, 0, 32'h40000000, 0, 1, 0, 4, 0));
		send_beat(tri_of(0, 0, 0, 1, 0, 32'h40000000, 0, 1, 0, -4, 0));
	endtask

	function automatic int near(int c, int span);
		return c + $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic test_random(int count);
		tpd_in_t t;
		int kind, span, c, k;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 8)
				no_gaps = !no_gaps;
			kind = $urandom_range(0, 9);
			span = 1 << $urandom_range(1, 20);
			c = $urandom;
			if (kind < 3) begin
				t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom};
			end else if (kind < 8) begin
				t = tri_of(near(c, span), near(c, span), near(c, span), near(c, span),
					near(c, span), near(c, span), near(c, span), near(c, span),
					near(c, span), near(c, 4 * span), near(c, 4 * span));
				t.vertex0_z = $urandom;
				t.vertex1_z = t.vertex0_z + near(0, span);
				t.vertex2_z = t.vertex0_z + near(0, span);
			end else begin
				t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom};
				k = $signed($urandom_range(0, 6)) - 3;
				t.vertex0_x = near(c, span);
				t.vertex0_y = near(c, span);
				t.vertex1_x = t.vertex0_x + near(0, 64);
				t.vertex1_y = t.vertex0_y + near(0, 64);
				t.vertex2_x = t.vertex0_x + k * (t.vertex1_x - t.vertex0_x);
				t.vertex2_y = t.vertex0_y + k * (t.vertex1_y - t.vertex0_y);
			end
			send_beat(t);
		end
	endtask

	initial begin
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_degenerate();
		test_rounding();
		test_saturation();
		test_random(1200);
		start <= 1'b0;
		while (depth_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Sent %0d triangles, checked %0d depths (%0d degenerate, %0d saturated).",
			n_sent, n_checked, n_degen, n_sat);
		if (errors == 0)
			$display("** triangle_plane_depth: PASSED **");
		else
			$display("** triangle_plane_depth: FAILED **");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timed out with %0d results outstanding.", depth_q.size());
		$display("** triangle_plane_depth: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tpd_pkg.sv
rtl/core/triangle_plane_depth.sv
verif/tb_triangle_plane_depth.sv
